// ===== design/tpqi_pkg.sv =====
// Shared types and constants for the tabulated potential interpolator.
// Used by the front end, the evaluation back end and the top level.
`default_nettype none

package tpqi_pkg;

   localparam int COL_W      = 4;
   localparam int IDX_W      = 10;
   localparam int DATA_W     = 32;
   localparam int LIM_W      = IDX_W + 2;
   localparam int CHI_W      = 16;
   localparam int WT_W       = 15;
   localparam int QUEUE_DEPTH = 4;

   localparam int REQ_USER_W = 2;
   localparam int REQ_DATA_W = 200;
   localparam int RSP_DATA_W = 2 * DATA_W;

   // req_tdata field positions
   localparam int COLUMN_LSB = 0;
   localparam int DIST_LSB   = 4;
   localparam int SIDX_LSB   = 36;
   localparam int SVAL_LSB   = 46;
   localparam int BEGIN_LSB  = 78;
   localparam int INV_LSB    = 142;
   localparam int FIRST_LSB  = 174;
   localparam int LAST_LSB   = 184;

   typedef enum logic [REQ_USER_W-1:0] {
      REQ_EVAL   = 2'd0,
      REQ_SAMPLE = 2'd1,
      REQ_RANGE  = 2'd2,
      REQ_BOUNDS = 2'd3
   } req_kind_type;

   // control carried through the queue with each word
   typedef struct packed {
      logic             eval;
      logic [2:0]       hit;
      logic [CHI_W-1:0] chi;
      logic [WT_W-1:0]  weight;
   } fb_ctl_type;

endpackage

`default_nettype wire

// ===== design/tpqi_fifo.sv =====
// Small register FIFO that decouples the front end from the back end.
// Generic; no package dependency.
`default_nettype none

module tpqi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/tpqi_front.sv =====
// Front end: accepts request words, keeps the column descriptors, forms the
// sample index, fraction and read addresses. Depends on tpqi_pkg.
`default_nettype none

module tpqi_front #(
   parameter int TABLE_DEPTH = 1024,
   parameter int NUM_COLUMNS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tpqi_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [tpqi_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               push,
   input  logic                               queue_full,
   output tpqi_pkg::fb_ctl_type               push_ctl,
   output logic [$clog2(TABLE_DEPTH)-1:0]     push_addr0,
   output logic [$clog2(TABLE_DEPTH)-1:0]     push_addr1,
   output logic [$clog2(TABLE_DEPTH)-1:0]     push_addr2,
   output logic [tpqi_pkg::DATA_W-1:0]        push_istep,
   output logic [tpqi_pkg::DATA_W-1:0]        push_wdata
);

   import tpqi_pkg::*;

   localparam int TAW      = $clog2(TABLE_DEPTH);
   localparam int COL_AW   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam int MAX_ADDR = TABLE_DEPTH - 1;

   // request fields
   req_kind_type      in_kind;
   logic [COL_W-1:0]  in_column;
   logic [DATA_W-1:0] in_dist, in_sval, in_begin, in_inv;
   logic [IDX_W-1:0]  in_sidx, in_first, in_last;

   assign in_kind   = req_kind_type'(req_tuser);
   assign in_column = req_tdata[COLUMN_LSB +: COL_W];
   assign in_dist   = req_tdata[DIST_LSB +: DATA_W];
   assign in_sidx   = req_tdata[SIDX_LSB +: IDX_W];
   assign in_sval   = req_tdata[SVAL_LSB +: DATA_W];
   assign in_begin  = req_tdata[BEGIN_LSB +: DATA_W];
   assign in_inv    = req_tdata[INV_LSB +: DATA_W];
   assign in_first  = req_tdata[FIRST_LSB +: IDX_W];
   assign in_last   = req_tdata[LAST_LSB +: IDX_W];

   logic              advance, accept, col_ok;
   logic [COL_AW-1:0] col_idx;
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;

   assign advance    = !(s3_valid_ff && queue_full);
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign col_ok     = (32'(in_column) < NUM_COLUMNS);
   assign col_idx    = COL_AW'(in_column);

   // column descriptors; spacing itself is never needed, only its inverse
   logic [DATA_W-1:0] start_ff [NUM_COLUMNS];
   logic [DATA_W-1:0] inv_ff   [NUM_COLUMNS];
   logic [IDX_W-1:0]  first_ff [NUM_COLUMNS];
   logic [IDX_W-1:0]  last_ff  [NUM_COLUMNS];

   always_ff @(posedge clock) begin
      if (accept && col_ok) begin
         case (in_kind)
            REQ_RANGE: begin
               start_ff[col_idx] <= in_begin;
               inv_ff[col_idx]   <= in_inv;
            end
            REQ_BOUNDS: begin
               first_ff[col_idx] <= in_first;
               last_ff[col_idx]  <= in_last;
            end
            default: ;
         endcase
      end
   end

   // only evaluations and in-range sample writes go on to the back end
   logic s1_valid_in;

   always_comb begin
      case (in_kind)
         REQ_EVAL:   s1_valid_in = accept;
         REQ_SAMPLE: s1_valid_in = accept && (32'(in_sidx) < TABLE_DEPTH);
         default:    s1_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1: descriptor lookup
   logic              s1_eval_ff, s1_colok_ff;
   logic [DATA_W-1:0] s1_dist_ff, s1_start_ff, s1_inv_ff, s1_wdata_ff;
   logic [IDX_W-1:0]  s1_first_ff, s1_last_ff;
   logic [TAW-1:0]    s1_waddr_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_eval_ff  <= (in_kind == REQ_EVAL);
         s1_colok_ff <= col_ok;
         s1_dist_ff  <= in_dist;
         s1_start_ff <= col_ok ? start_ff[col_idx] : '0;
         s1_inv_ff   <= col_ok ? inv_ff[col_idx] : '0;
         s1_first_ff <= col_ok ? first_ff[col_idx] : '0;
         s1_last_ff  <= col_ok ? last_ff[col_idx] : '0;
         s1_waddr_ff <= TAW'(in_sidx);
         s1_wdata_ff <= in_sval;
      end
   end

   // stage 2: clamped offset and index headroom
   logic [DATA_W-1:0]       s2_rr_in;
   logic [IDX_W-1:0]        eff_last;
   logic signed [LIM_W-1:0] s2_lim_in;

   always_comb begin
      s2_rr_in = (s1_dist_ff > s1_start_ff) ? s1_dist_ff - s1_start_ff : '0;
      eff_last = (32'(s1_last_ff) > MAX_ADDR) ? IDX_W'(MAX_ADDR) : s1_last_ff;
      // a bad column gets a negative headroom so every sample reads as zero
      s2_lim_in = s1_colok_ff
                ? $signed({2'b00, eff_last}) - $signed({2'b00, s1_first_ff})
                : '1;
   end

   logic                    s2_eval_ff;
   logic [DATA_W-1:0]       s2_rr_ff, s2_inv_ff, s2_wdata_ff;
   logic signed [LIM_W-1:0] s2_lim_ff;
   logic [IDX_W-1:0]        s2_first_ff;
   logic [TAW-1:0]          s2_waddr_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_eval_ff  <= s1_eval_ff;
         s2_rr_ff    <= s2_rr_in;
         s2_inv_ff   <= s1_inv_ff;
         s2_lim_ff   <= s2_lim_in;
         s2_first_ff <= s1_first_ff;
         s2_waddr_ff <= s1_waddr_ff;
         s2_wdata_ff <= s1_wdata_ff;
      end
   end

   // stage 3: offset times inverse spacing, Q32.32
   logic                    s3_eval_ff;
   logic [2*DATA_W-1:0]     s3_prod_ff;
   logic [DATA_W-1:0]       s3_inv_ff, s3_wdata_ff;
   logic signed [LIM_W-1:0] s3_lim_ff;
   logic [IDX_W-1:0]        s3_first_ff;
   logic [TAW-1:0]          s3_waddr_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_eval_ff  <= s2_eval_ff;
         s3_prod_ff  <= s2_rr_ff * s2_inv_ff;
         s3_inv_ff   <= s2_inv_ff;
         s3_lim_ff   <= s2_lim_ff;
         s3_first_ff <= s2_first_ff;
         s3_waddr_ff <= s2_waddr_ff;
         s3_wdata_ff <= s2_wdata_ff;
      end
   end

   // queue entry: hit flags, fraction, weight, the three addresses, inverse spacing and write data
   logic [DATA_W-1:0]        k;
   logic [CHI_W-1:0]         chi;
   logic [CHI_W:0]           chi_c;
   logic [2*CHI_W:0]         wprod;
   logic signed [DATA_W:0]   k_s, lim0_s, lim1_s, lim2_s;
   logic [TAW-1:0]           base;

   always_comb begin
      k      = s3_prod_ff[2*DATA_W-1:DATA_W];
      chi    = s3_prod_ff[DATA_W-1:DATA_W-CHI_W];
      chi_c  = (CHI_W + 1)'(1 << CHI_W) - (CHI_W + 1)'(chi);
      wprod  = chi * chi_c;
      // a + i <= last  <=>  k <= (last - first) - i, so no wide add on k
      k_s    = $signed({1'b0, k});
      lim0_s = (DATA_W + 1)'(s3_lim_ff);
      lim1_s = lim0_s - (DATA_W + 1)'(1);
      lim2_s = lim0_s - (DATA_W + 1)'(2);
      base   = TAW'(k) + TAW'(s3_first_ff);

      push_ctl.eval   = s3_eval_ff;
      push_ctl.hit[0] = (k_s <= lim0_s);
      push_ctl.hit[1] = (k_s <= lim1_s);
      push_ctl.hit[2] = (k_s <= lim2_s);
      push_ctl.chi    = chi;
      push_ctl.weight = wprod[CHI_W +: WT_W];

      push_addr0 = s3_eval_ff ? base : s3_waddr_ff;
      push_addr1 = base + TAW'(1);
      push_addr2 = base + TAW'(2);
      push_istep = s3_inv_ff;
      push_wdata = s3_wdata_ff;
   end

   assign push = s3_valid_ff && !queue_full;

endmodule

`default_nettype wire

// ===== design/tpqi_back.sv =====
// Back end: sample memory (three copies, one read port each), quadratic
// interpolation datapath, saturation and the result register. Uses tpqi_pkg.
`default_nettype none

module tpqi_back #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   output logic                               pop,
   input  logic                               queue_empty,
   input  tpqi_pkg::fb_ctl_type               pop_ctl,
   input  logic [$clog2(TABLE_DEPTH)-1:0]     pop_addr0,
   input  logic [$clog2(TABLE_DEPTH)-1:0]     pop_addr1,
   input  logic [$clog2(TABLE_DEPTH)-1:0]     pop_addr2,
   input  logic [tpqi_pkg::DATA_W-1:0]        pop_istep,
   input  logic [tpqi_pkg::DATA_W-1:0]        pop_wdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tpqi_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // potential, gradient
   output logic [0:0]                         rsp_tuser    // saturated
);

   import tpqi_pkg::*;

   localparam int DV_W  = DATA_W + 1;
   localparam int D2_W  = DATA_W + 2;
   localparam int M1_W  = CHI_W + 1 + DV_W;
   localparam int M2_W  = WT_W + 1 + D2_W;
   localparam int M3_W  = CHI_W + 1 + D2_W;
   localparam int ACC_W = M3_W + 2;
   localparam int POT_W = ACC_W - (CHI_W + 1);
   localparam int INS_W = M3_W + 1;
   localparam int INN_W = INS_W - CHI_W;
   localparam int IH_W  = INN_W - CHI_W;
   localparam int PH_W  = IH_W + DATA_W + 1;
   localparam int PL_W  = CHI_W + DATA_W;
   localparam int GR_W  = PH_W + 1;

   typedef struct packed {
      logic              flag;
      logic [DATA_W-1:0] value;
   } clip_type;

   function automatic clip_type clip_word(input logic signed [63:0] v);
      clip_type r;
      r.flag  = 1'b0;
      r.value = v[DATA_W-1:0];
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r.flag  = 1'b1;
         r.value = 32'h7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r.flag  = 1'b1;
         r.value = 32'h8000_0000;
      end
      return r;
   endfunction

   logic o_valid_ff;
   logic advance;

   // the whole back end stalls as one while a result waits
   assign advance = !(o_valid_ff && !rsp_tready);
   assign pop     = advance && !queue_empty;

   logic write_word;
   assign write_word = pop && !pop_ctl.eval;

   // sample memory, written identically in each copy
   logic [DATA_W-1:0] samp0_mem [TABLE_DEPTH];
   logic [DATA_W-1:0] samp1_mem [TABLE_DEPTH];
   logic [DATA_W-1:0] samp2_mem [TABLE_DEPTH];
   logic [DATA_W-1:0] rd0_ff, rd1_ff, rd2_ff;

   always_ff @(posedge clock) begin
      if (write_word) begin
         samp0_mem[pop_addr0] <= pop_wdata;
      end
      if (advance) begin
         rd0_ff <= samp0_mem[pop_addr0];
      end
   end

   always_ff @(posedge clock) begin
      if (write_word) begin
         samp1_mem[pop_addr0] <= pop_wdata;
      end
      if (advance) begin
         rd1_ff <= samp1_mem[pop_addr1];
      end
   end

   always_ff @(posedge clock) begin
      if (write_word) begin
         samp2_mem[pop_addr0] <= pop_wdata;
      end
      if (advance) begin
         rd2_ff <= samp2_mem[pop_addr2];
      end
   end

   logic b0_valid_ff, b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else if (advance) begin
         b0_valid_ff <= pop && pop_ctl.eval;
         b1_valid_ff <= b0_valid_ff;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
         o_valid_ff  <= b4_valid_ff;
      end
   end

   // stage 0: memory read
   logic [2:0]        b0_hit_ff;
   logic [CHI_W-1:0]  b0_chi_ff;
   logic [WT_W-1:0]   b0_weight_ff;
   logic [DATA_W-1:0] b0_istep_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         b0_hit_ff    <= pop_ctl.hit;
         b0_chi_ff    <= pop_ctl.chi;
         b0_weight_ff <= pop_ctl.weight;
         b0_istep_ff  <= pop_istep;
      end
   end

   // stage 1: samples past the column end read as zero; differences
   logic signed [DATA_W-1:0] p0, p1, p2;
   logic signed [DV_W-1:0]   b1_dv_in;
   logic signed [D2_W-1:0]   b1_d2v_in;

   always_comb begin
      p0 = b0_hit_ff[0] ? $signed(rd0_ff) : '0;
      p1 = b0_hit_ff[1] ? $signed(rd1_ff) : '0;
      p2 = b0_hit_ff[2] ? $signed(rd2_ff) : '0;
      b1_dv_in  = DV_W'(p1) - DV_W'(p0);
      b1_d2v_in = D2_W'(p2) - (D2_W'(p1) <<< 1) + D2_W'(p0);
   end

   logic signed [DATA_W-1:0] b1_p0_ff;
   logic signed [DV_W-1:0]   b1_dv_ff;
   logic signed [D2_W-1:0]   b1_d2v_ff;
   logic [CHI_W-1:0]         b1_chi_ff;
   logic [WT_W-1:0]          b1_weight_ff;
   logic [DATA_W-1:0]        b1_istep_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_p0_ff     <= p0;
         b1_dv_ff     <= b1_dv_in;
         b1_d2v_ff    <= b1_d2v_in;
         b1_chi_ff    <= b0_chi_ff;
         b1_weight_ff <= b0_weight_ff;
         b1_istep_ff  <= b0_istep_ff;
      end
   end

   // stage 2: the three products
   logic signed [CHI_W:0] chi_s, chi_off;
   logic signed [WT_W:0]  wt_s;

   always_comb begin
      chi_s   = $signed({1'b0, b1_chi_ff});
      chi_off = chi_s - $signed((CHI_W + 1)'(1 << (CHI_W - 1)));
      wt_s    = $signed({1'b0, b1_weight_ff});
   end

   logic signed [M1_W-1:0]   b2_m1_ff;
   logic signed [M2_W-1:0]   b2_m2_ff;
   logic signed [M3_W-1:0]   b2_m3_ff;
   logic signed [DATA_W-1:0] b2_p0_ff;
   logic signed [DV_W-1:0]   b2_dv_ff;
   logic [DATA_W-1:0]        b2_istep_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         b2_m1_ff    <= chi_s * b1_dv_ff;
         b2_m2_ff    <= wt_s * b1_d2v_ff;
         b2_m3_ff    <= chi_off * b1_d2v_ff;
         b2_p0_ff    <= b1_p0_ff;
         b2_dv_ff    <= b1_dv_ff;
         b2_istep_ff <= b1_istep_ff;
      end
   end

   // stage 3: potential p0 + chi*dv - w*d2v/2, and the derivative term
   logic signed [ACC_W-1:0] acc;
   logic signed [INS_W-1:0] inner_sum;

   always_comb begin
      acc = (ACC_W'(b2_p0_ff) <<< (CHI_W + 1)) + (ACC_W'(b2_m1_ff) <<< 1)
          - ACC_W'(b2_m2_ff);
      inner_sum = (INS_W'(b2_dv_ff) <<< CHI_W) + INS_W'(b2_m3_ff);
   end

   logic signed [POT_W-1:0] b3_pot_ff;
   logic signed [INN_W-1:0] b3_inner_ff;
   logic [DATA_W-1:0]       b3_istep_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         b3_pot_ff   <= acc[ACC_W-1:CHI_W+1];
         b3_inner_ff <= inner_sum[INS_W-1:CHI_W];
         b3_istep_ff <= b2_istep_ff;
      end
   end

   // stage 4: clip potential; derivative times inverse spacing in two halves
   clip_type               pot_clip;
   logic signed [IH_W-1:0] inner_hi;
   logic [CHI_W-1:0]       inner_lo;
   logic signed [DATA_W:0] istep_s;

   always_comb begin
      pot_clip = clip_word(64'(b3_pot_ff));
      inner_hi = b3_inner_ff[INN_W-1:CHI_W];
      inner_lo = b3_inner_ff[CHI_W-1:0];
      istep_s  = $signed({1'b0, b3_istep_ff});
   end

   logic [DATA_W-1:0]      b4_pot_ff;
   logic                   b4_sat_ff;
   logic signed [PH_W-1:0] b4_ph_ff;
   logic [PL_W-1:0]        b4_pl_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         b4_pot_ff <= pot_clip.value;
         b4_sat_ff <= pot_clip.flag;
         b4_ph_ff  <= inner_hi * istep_s;
         b4_pl_ff  <= inner_lo * b3_istep_ff;
      end
   end

   // stage 5: recombine, floor by 2^16 falls out of the split
   logic signed [GR_W-1:0] grad_full;
   clip_type               grad_clip;

   always_comb begin
      grad_full = GR_W'(b4_ph_ff) + GR_W'($signed({1'b0, b4_pl_ff[PL_W-1:CHI_W]}));
      grad_clip = clip_word(64'(grad_full));
   end

   logic [DATA_W-1:0] o_pot_ff, o_grad_ff;
   logic              o_sat_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         o_pot_ff  <= b4_pot_ff;
         o_grad_ff <= grad_clip.value;
         o_sat_ff  <= b4_sat_ff || grad_clip.flag;
      end
   end

   assign rsp_tvalid   = o_valid_ff;
   assign rsp_tdata    = {o_grad_ff, o_pot_ff};
   assign rsp_tuser[0] = o_sat_ff;

endmodule

`default_nettype wire

// ===== design/tabulated_potential_quadratic_interp.sv =====
// Tabulated pair potential with three-point quadratic interpolation.
// Joins the front end, the decoupling queue and the back end; uses tpqi_pkg.
//
// Takes one request word per clock while req_tready is high and returns one
// result word per evaluate request, in order; sample and descriptor writes
// give no result. A result passes three front stages, the queue and six
// back stages. The sustained rate is one word per cycle while rsp_tready is
// high, set by the three sample memory copies that read three successive
// samples in the same cycle. Writes take effect for every later request.
// The sample memory and the column descriptors are not cleared at reset:
// load them before evaluating. Potential and gradient are signed Q16.16;
// the saturated flag rides in rsp_tuser.
`default_nettype none

module tabulated_potential_quadratic_interp #(
   parameter int TABLE_DEPTH = 1024,
   parameter int NUM_COLUMNS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // column, distance, sample_index, sample_value, range_begin, range_step,
   // range_inv_step, first_index, last_index; zero fill to 200 bits
   input  logic [tpqi_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [tpqi_pkg::REQ_USER_W-1:0]    req_tuser,   // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tpqi_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // potential, gradient
   output logic [0:0]                         rsp_tuser    // saturated
);

   import tpqi_pkg::*;

   localparam int TAW = $clog2(TABLE_DEPTH);
   localparam int QW  = $bits(fb_ctl_type) + 3 * TAW + 2 * DATA_W;

   logic              push, pop, queue_full, queue_empty;
   fb_ctl_type        push_ctl, pop_ctl;
   logic [TAW-1:0]    push_addr0, push_addr1, push_addr2;
   logic [TAW-1:0]    pop_addr0, pop_addr1, pop_addr2;
   logic [DATA_W-1:0] push_istep, push_wdata, pop_istep, pop_wdata;
   logic [QW-1:0]     push_word, pop_word;

   assign push_word = {push_ctl, push_addr2, push_addr1, push_addr0, push_istep, push_wdata};
   assign {pop_ctl, pop_addr2, pop_addr1, pop_addr0, pop_istep, pop_wdata} = pop_word;

   tpqi_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .NUM_COLUMNS (NUM_COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .queue_full (queue_full),
      .push_ctl   (push_ctl),
      .push_addr0 (push_addr0),
      .push_addr1 (push_addr1),
      .push_addr2 (push_addr2),
      .push_istep (push_istep),
      .push_wdata (push_wdata)
   );

   tpqi_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_word),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_word),
      .empty     (queue_empty)
   );

   tpqi_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop         (pop),
      .queue_empty (queue_empty),
      .pop_ctl     (pop_ctl),
      .pop_addr0   (pop_addr0),
      .pop_addr1   (pop_addr1),
      .pop_addr2   (pop_addr2),
      .pop_istep   (pop_istep),
      .pop_wdata   (pop_wdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tabulated_potential_quadratic_interp_test.sv =====
// Self-checking bench for the tabulated potential interpolator: loads tables, evaluates
// distances and checks potential, gradient and saturation against its own arithmetic.
// Depends on tpqi_pkg and tabulated_potential_quadratic_interp.
module tabulated_potential_quadratic_interp_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tpqi_pkg::*;

   localparam int SAMPLE_SLOTS = 1024;
   localparam int COLUMNS = 16;
   localparam int WORD_GOAL = 600;
   localparam int LONG_STALL = 400;

   typedef struct {
      req_kind_type kind;
      logic [3:0]   column;
      logic [31:0]  distance;
      logic [9:0]   sidx;
      logic [31:0]  sval;
      logic [31:0]  rbegin;
      logic [31:0]  rstep;
      logic [31:0]  rinv;
      logic [9:0]   first_idx;
      logic [9:0]   last_idx;
   } pair_req_type;

   typedef struct {
      logic [31:0] potential;
      logic [31:0] gradient;
      logic        saturated;
   } pair_force_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = REQ_EVAL;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;

   tabulated_potential_quadratic_interp #(
      .TABLE_DEPTH(SAMPLE_SLOTS),
      .NUM_COLUMNS(COLUMNS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   pair_req_type   request_backlog[$];
   pair_force_type forces_due[$];
   pair_req_type   on_bus;
   int             words_taken = 0;
   bit             failed = 1'b0;
   logic           calm = 1'b0;

   // table image as the block should hold it, updated on acceptance
   logic [31:0] mem_sample[SAMPLE_SLOTS];
   logic [31:0] col_begin[COLUMNS];
   logic [31:0] col_inv[COLUMNS];
   logic [9:0]  col_first[COLUMNS];
   logic [9:0]  col_last[COLUMNS];

   // what the stimulus has loaded so far, so no unwritten entry is ever read
   bit          g_written[SAMPLE_SLOTS];
   bit          g_has_range[COLUMNS];
   bit          g_has_bounds[COLUMNS];
   logic [31:0] g_begin[COLUMNS];
   logic [31:0] g_inv[COLUMNS];
   logic [9:0]  g_first[COLUMNS];
   logic [9:0]  g_last[COLUMNS];
   int          pushed = 0;

   initial forever #6 clock = ~clock;

   // ---------------------------------------------------------------- arithmetic

   function automatic longint tap(input logic [63:0] addr, input logic [9:0] lim);
      if (addr > {54'd0, lim} || addr >= SAMPLE_SLOTS)
         return 0;
      return longint'(signed'(mem_sample[addr[9:0]]));
   endfunction

   // bit 32 flags a clip to the Q16.16 range
   function automatic logic [32:0] clip_q16(input logic signed [95:0] v);
      if (v > 96'sd2147483647)
         return {1'b1, 32'h7FFF_FFFF};
      if (v < -96'sd2147483648)
         return {1'b1, 32'h8000_0000};
      return {1'b0, v[31:0]};
   endfunction

   task automatic apply_request(input pair_req_type w);
      logic [31:0]          rr;
      logic [63:0]          prod;
      logic [63:0]          addr;
      longint               chi, p0, p1, p2, dv, d2v, wt, acc, pot, inner;
      logic signed [95:0]   grad;
      logic [32:0]          pot_c, grad_c;
      case (w.kind)
         REQ_SAMPLE: mem_sample[w.sidx] = w.sval;
         REQ_RANGE: begin
            col_begin[w.column] = w.rbegin;
            col_inv[w.column] = w.rinv;
         end
         REQ_BOUNDS: begin
            col_first[w.column] = w.first_idx;
            col_last[w.column] = w.last_idx;
         end
         default: begin
            rr = (w.distance > col_begin[w.column]) ? w.distance - col_begin[w.column] : 32'd0;
            prod = {32'd0, rr} * {32'd0, col_inv[w.column]};
            chi = longint'(prod[31:16]);
            addr = {32'd0, prod[63:32]} + {54'd0, col_first[w.column]};
            p0 = tap(addr, col_last[w.column]);
            p1 = tap(addr + 64'd1, col_last[w.column]);
            p2 = tap(addr + 64'd2, col_last[w.column]);
            dv = p1 - p0;
            d2v = p2 - 2 * p1 + p0;
            wt = (chi * (65536 - chi)) / 65536;
            acc = p0 * 131072 + 2 * chi * dv - wt * d2v;
            pot = acc >>> 17;
            inner = (dv * 65536 + (chi - 32768) * d2v) >>> 16;
            grad = inner;
            grad = (grad * $signed({64'd0, col_inv[w.column]})) >>> 16;
            pot_c = clip_q16(pot);
            grad_c = clip_q16(grad);
            forces_due.push_back('{pot_c[31:0], grad_c[31:0], pot_c[32] | grad_c[32]});
         end
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus

   // fields a word does not use carry random junk
   function automatic pair_req_type noise_word(input req_kind_type kind);
      pair_req_type w;
      w.kind = kind;
      w.column = 4'($urandom);
      w.distance = $urandom;
      w.sidx = 10'($urandom);
      w.sval = $urandom;
      w.rbegin = $urandom;
      w.rstep = $urandom;
      w.rinv = $urandom;
      w.first_idx = 10'($urandom);
      w.last_idx = 10'($urandom);
      return w;
   endfunction

   function automatic logic [31:0] any_sample();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_sample(input logic [9:0] idx, input logic [31:0] val);
      pair_req_type w;
      w = noise_word(REQ_SAMPLE);
      w.sidx = idx;
      w.sval = val;
      g_written[idx] = 1'b1;
      request_backlog.push_back(w);
      pushed++;
   endtask

   task automatic push_range(input logic [3:0] c, input logic [31:0] b,
                             input logic [31:0] s, input logic [31:0] inv);
      pair_req_type w;
      w = noise_word(REQ_RANGE);
      w.column = c;
      w.rbegin = b;
      w.rstep = s;
      w.rinv = inv;
      g_has_range[c] = 1'b1;
      g_begin[c] = b;
      g_inv[c] = inv;
      request_backlog.push_back(w);
      pushed++;
   endtask

   task automatic push_bounds(input logic [3:0] c, input logic [9:0] f, input logic [9:0] l);
      pair_req_type w;
      w = noise_word(REQ_BOUNDS);
      w.column = c;
      w.first_idx = f;
      w.last_idx = l;
      g_has_bounds[c] = 1'b1;
      g_first[c] = f;
      g_last[c] = l;
      request_backlog.push_back(w);
      pushed++;
   endtask

   // loads any sample the evaluate would read that has not been written yet
   task automatic push_eval(input logic [3:0] c, input logic [31:0] pair_dist);
      pair_req_type w;
      logic [31:0]  rr;
      logic [63:0]  a;
      rr = (pair_dist > g_begin[c]) ? pair_dist - g_begin[c] : 32'd0;
      a = (({32'd0, rr} * {32'd0, g_inv[c]}) >> 32) + {54'd0, g_first[c]};
      for (int i = 0; i < 3; i++) begin
         if (a + i <= {54'd0, g_last[c]} && a + i < SAMPLE_SLOTS && !g_written[a + i])
            push_sample(10'(a + i), any_sample());
      end
      w = noise_word(REQ_EVAL);
      w.column = c;
      w.distance = pair_dist;
      request_backlog.push_back(w);
      pushed++;
   endtask

   task automatic fill_random();
      int          roll;
      int          span;
      logic [3:0]  c;
      logic [9:0]  f;
      logic [31:0] pair_dist, k;
      logic [63:0] aim, rr64;
      while (pushed < WORD_GOAL) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            f = 10'($urandom);
            if ($urandom_range(0, 4) == 0)
               push_bounds(4'($urandom), f, 10'($urandom));
            else
               push_bounds(4'($urandom), f, 10'((f + $urandom_range(0, 48) > 1023) ?
                                                1023 : f + $urandom_range(0, 48)));
         end else if (roll < 14) begin
            case ($urandom_range(0, 3))
               0: k = $urandom;
               1: k = $urandom_range(0, 32'h0004_0000);
               2: k = 32'h0001_0000 << $urandom_range(0, 15);
               default: k = $urandom_range(32'h0000_8000, 32'h0002_0000);
            endcase
            push_range(4'($urandom),
                       ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000),
                       $urandom, k);
         end else if (roll < 24) begin
            push_sample(10'($urandom), any_sample());
         end else begin
            do c = 4'($urandom); while (!(g_has_range[c] && g_has_bounds[c]));
            roll = $urandom_range(0, 19);
            if (roll < 14 && g_inv[c] != 0) begin
               // aim at a chosen index inside, or just past, the column
               span = (g_last[c] >= g_first[c]) ? g_last[c] - g_first[c] : 0;
               k = $urandom_range(0, span + 2);
               aim = {k, $urandom};
               rr64 = (aim + g_inv[c] - 64'd1) / g_inv[c];
               if (rr64 + g_begin[c] > 64'hFFFF_FFFF)
                  pair_dist = $urandom;
               else
                  pair_dist = g_begin[c] + rr64[31:0];
            end else if (roll < 17) begin
               k = $urandom_range(0, 1000);
               pair_dist = (g_begin[c] > k) ? g_begin[c] - k : 32'd0;
            end else begin
               pair_dist = $urandom;
            end
            push_eval(c, pair_dist);
         end
      end
   endtask

   initial begin
      // extremes of the samples, below the start, mid interval, past the column end
      push_bounds(4'd0, 10'd0, 10'd3);
      push_range(4'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      push_sample(10'd0, 32'h7FFF_FFFF);
      push_sample(10'd1, 32'h8000_0000);
      push_sample(10'd2, 32'h7FFF_FFFF);
      push_sample(10'd3, 32'h0000_0000);
      push_eval(4'd0, 32'h0000_0000);
      push_eval(4'd0, 32'h0001_8000);
      push_eval(4'd0, 32'h0002_C000);
      push_eval(4'd0, 32'h0004_8000);
      push_eval(4'd0, 32'hFFFF_FFFF);
      // widest inverse spacing: fraction all ones, and an index far past the memory
      push_bounds(4'd15, 10'd1020, 10'd1023);
      push_range(4'd15, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_eval(4'd15, 32'hFFFF_FFFF);
      push_eval(4'd15, 32'h0000_0001);
      push_eval(4'd15, 32'h0000_8000);
      // zero inverse spacing, start at the top of the range
      push_range(4'd1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      push_bounds(4'd1, 10'd5, 10'd5);
      push_eval(4'd1, 32'hFFFF_FFFF);
      push_eval(4'd1, 32'h1234_5678);
      // reads running off the end of the sample memory
      push_range(4'd2, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
      push_bounds(4'd2, 10'd1023, 10'd1023);
      push_eval(4'd2, 32'h0000_8000);
      // last index below first
      push_bounds(4'd3, 10'd10, 10'd4);
      push_range(4'd3, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
      push_eval(4'd3, 32'h0003_0000);
      fill_random();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (forces_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (!failed)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #10ms;
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------- request side

   int tx_gap = 0;
   int tx_run = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         calm <= 1'b0;
      end else begin
         calm <= request_backlog.size() < 40;
         if (req_tvalid && req_tready) begin
            apply_request(on_bus);
            words_taken <= words_taken + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (!calm && tx_gap > 0) begin
               tx_gap <= tx_gap - 1;
               req_tvalid <= 1'b0;
            end else if (request_backlog.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               on_bus = request_backlog.pop_front();
               req_tuser <= on_bus.kind;
               req_tdata <= {6'd0, on_bus.last_idx, on_bus.first_idx, on_bus.rinv,
                             on_bus.rstep, on_bus.rbegin, on_bus.sval, on_bus.sidx,
                             on_bus.distance, on_bus.column};
               req_tvalid <= 1'b1;
               if (tx_run > 0)
                  tx_run <= tx_run - 1;
               else if ($urandom_range(0, 3) == 0)
                  tx_gap <= $urandom_range(1, 17);
               else
                  tx_run <= $urandom_range(1, 60);
            end
         end
      end
   end

   // ---------------------------------------------------------------- result side

   int rx_gap = 0;
   int rx_run = 0;
   int stall_left = 0;
   bit stall_done = 1'b0;

   // one long hold-off so the pipeline and queue back up into the request side
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (!stall_done && words_taken >= 250) begin
         stall_left <= LONG_STALL;
         stall_done <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else if (rx_gap > 0) begin
         rsp_tready <= 1'b0;
         rx_gap <= rx_gap - 1;
      end else if (rx_run > 0) begin
         rsp_tready <= 1'b1;
         rx_run <= rx_run - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         rx_gap <= $urandom_range(0, 16);
      end else begin
         rsp_tready <= 1'b1;
         rx_run <= $urandom_range(1, 60);
      end
   end

   always @(posedge clock) begin
      pair_force_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (forces_due.size() == 0) begin
            $display("%0t: result word with none due: data %h sat %b",
                     $time, rsp_tdata, rsp_tuser);
            failed = 1'b1;
         end else begin
            due = forces_due.pop_front();
            if (rsp_tdata[31:0] !== due.potential) begin
               $display("%0t: potential expected %h got %h", $time, due.potential,
                        rsp_tdata[31:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[63:32] !== due.gradient) begin
               $display("%0t: gradient expected %h got %h", $time, due.gradient,
                        rsp_tdata[63:32]);
               failed = 1'b1;
            end
            if (rsp_tuser[0] !== due.saturated) begin
               $display("%0t: saturated expected %b got %b", $time, due.saturated,
                        rsp_tuser[0]);
               failed = 1'b1;
            end
         end
      end
   end

endmodule

// ===== filelist.f =====
design/tpqi_pkg.sv
design/tpqi_fifo.sv
design/tpqi_front.sv
design/tpqi_back.sv
design/tabulated_potential_quadratic_interp.sv
tb/sv/tabulated_potential_quadratic_interp_test.sv
